/* sv/pdws_pkg.sv */
// Shared types and constants for the weighted delay scheduler.
package pdws_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int FIFO_DEPTH  = 64;
    localparam int PTR_W       = 6;
    localparam int CNT_W       = 7;
    localparam int CLS_W       = 2;
    localparam int TIME_W      = 32;
    localparam int ADM_W       = 32;
    localparam int QSUM_W      = 38;
    localparam int DSUM_W      = 48;
    localparam int NT_W        = 39;
    localparam int NUM_W       = 49;
    localparam int DIV_W       = 50;
    localparam int DIV_STEPS   = 25;
    localparam int STEP_W      = 5;
    localparam int WT_W        = 16;
    localparam int PRI_W       = 64;
    localparam int MEM_AW      = 8;
    localparam int MEM_DEPTH   = NUM_CLASSES * FIFO_DEPTH;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_QLIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WT0  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WT1  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WT2  = 2'd3;

    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    typedef struct packed {
        logic             capture;
        logic             apply;
        logic             mul_nt;
        logic             load_num;
        logic             div_step;
        logic             eval;
        logic             rd_head;
        logic             pop;
        logic             load_out;
        logic [CLS_W-1:0] cls;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic found;
        logic out_free;
    } t_sts;

endpackage

/* sv/pad_weighted_delay_scheduler_core.sv */
// Top level of the three-class weighted average delay scheduler.
//  channel  direction  signals                          content
//  s        in         i_s_tvalid/o_s_tready            event, time in tdata, kind in tuser
//  m        out        o_m_tvalid/i_m_tready            one result per event
//  cfg      in         i_cfg_valid/o_cfg_ready          register index and data
// When the server stays busy an event only updates the statistics; otherwise it evaluates the
// three classes in turn, each around a radix-4 divide by the admitted count, then dispatches the best.
// Reset clears all counters, sums and the server; queue contents are not cleared.
// A finished result waits in the output register; the next event is taken meanwhile
// and holds in its last cycle until that result leaves.
module pad_weighted_delay_scheduler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pdws_pkg::TIME_W-1:0]         i_s_tdata,   // event_time
    input  logic [pdws_pkg::IN_USER_W-1:0]      i_s_tuser,   // req_type, class_id
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // admitted, dropped, service_started, served_class, served_wait, server_busy
    output logic [pdws_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pdws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdws_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pdws_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pdws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pdws_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_adm_drp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("admitted and dropped both set");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2]) |-> o_m_tdata[37])
        else $error("service started but server idle");
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("event taken while another is in work");
`endif

endmodule

/* sv/pdws_ctrl.sv */
// Sequencer for event update, per-class priority evaluation and dispatch.
module pdws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  pdws_pkg::t_sts i_sts,
    output pdws_pkg::t_cmd o_cmd
);
    import pdws_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVENT, ST_CHECK, ST_MUL, ST_NUM, ST_DIV,
        ST_EVAL, ST_RD, ST_POP, ST_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_cls   = r_cls;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.cls = r_cls;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_EVENT;
                end
            end
            ST_EVENT: begin
                o_cmd.apply = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_cls = '0;
                n_state = i_sts.busy ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_nt = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.load_num = 1'b1;
                n_step = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (r_cls == LAST_CLS) begin
                    n_state = ST_RD;
                end else begin
                    n_cls = r_cls + CLS_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state = i_sts.found ? ST_POP : ST_DONE;
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cls   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cls   <= n_cls;
            r_step  <= n_step;
        end
    end

endmodule

/* sv/pdws_dp.sv */
// Queues, per-class statistics, priority arithmetic and result register.
module pdws_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdws_pkg::t_cmd                      i_cmd,
    output pdws_pkg::t_sts                      o_sts,
    input  logic [pdws_pkg::IN_USER_W-1:0]      i_s_tuser,
    input  logic [pdws_pkg::TIME_W-1:0]         i_s_tdata,
    input  logic                                i_cfg_valid,
    input  logic [pdws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdws_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pdws_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import pdws_pkg::*;

    logic [TIME_W-1:0] r_mem [0:MEM_DEPTH-1];
    logic [TIME_W-1:0] r_rdata;

    logic              r_type;
    logic [CLS_W-1:0]  r_ecls;
    logic [TIME_W-1:0] r_time;

    logic [CNT_W-1:0]  r_qlim;
    logic [WT_W-1:0]   r_wt   [NUM_CLASSES];

    logic [PTR_W-1:0]  r_head [NUM_CLASSES];
    logic [PTR_W-1:0]  r_tail [NUM_CLASSES];
    logic [CNT_W-1:0]  r_cnt  [NUM_CLASSES];
    logic [ADM_W-1:0]  r_admt [NUM_CLASSES];
    logic [QSUM_W-1:0] r_qsum [NUM_CLASSES];
    logic [DSUM_W-1:0] r_dsum [NUM_CLASSES];

    logic              r_busy;
    logic [CLS_W-1:0]  r_scls;
    logic [TIME_W-1:0] r_sarr;

    logic              r_adm, r_drp, r_started;
    logic [TIME_W-1:0] r_wait;
    logic              r_found;
    logic [CLS_W-1:0]  r_best;
    logic [PRI_W-1:0]  r_bestp;

    logic [NT_W-1:0]   r_nt;
    logic [DIV_W-1:0]  r_quo;
    logic [ADM_W:0]    r_rem;

    logic              r_oval;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [CNT_W-1:0]  lim;
    logic              arr_ok;
    logic              arr_fit;
    logic [TIME_W-1:0] dly;
    logic [DSUM_W:0]   dsum_add;
    logic [QSUM_W:0]   qsum_add;
    logic [ADM_W:0]    admt_add;
    logic [NUM_W-1:0]  num_sum;
    logic [NUM_W-1:0]  num_val;
    logic [ADM_W:0]    rem1, rem2;
    logic              q1, q2;
    logic [DIV_W-1:0]  quo_sh;
    logic [NUM_W+WT_W-1:0] prod;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] pop_wait;

    assign lim     = (r_qlim > CNT_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : r_qlim;
    assign arr_ok  = !r_type && (r_ecls < CLS_W'(NUM_CLASSES));
    assign arr_fit = r_cnt[r_ecls] < lim;
    assign dly     = (r_time >= r_sarr) ? r_time - r_sarr : '0;
    assign dsum_add = {1'b0, r_dsum[r_scls]} + (DSUM_W+1)'(dly);
    assign qsum_add = {1'b0, r_qsum[r_ecls]} + (QSUM_W+1)'(r_time);
    assign admt_add = {1'b0, r_admt[r_ecls]} + (ADM_W+1)'(1);

    assign num_sum = NUM_W'(r_nt) + NUM_W'(r_dsum[i_cmd.cls]);
    assign num_val = (num_sum > NUM_W'(r_qsum[i_cmd.cls])) ?
                     num_sum - NUM_W'(r_qsum[i_cmd.cls]) : '0;

    always_comb begin
        logic [ADM_W:0] d;
        d    = {1'b0, r_admt[i_cmd.cls]};
        rem1 = {r_rem[ADM_W-1:0], r_quo[DIV_W-1]};
        q1   = (rem1 >= d);
        if (q1) rem1 = rem1 - d;
        rem2 = {rem1[ADM_W-1:0], r_quo[DIV_W-2]};
        q2   = (rem2 >= d);
        if (q2) rem2 = rem2 - d;
        quo_sh = {r_quo[DIV_W-3:0], q1, q2};
    end

    assign prod = NUM_W'(r_quo) * (NUM_W+WT_W)'(r_wt[i_cmd.cls]);
    assign pri  = (r_admt[i_cmd.cls] == '0) ? '0 :
                  (|prod[NUM_W+WT_W-1:PRI_W]) ? '1 : prod[PRI_W-1:0];
    assign pop_wait = (r_time >= r_rdata) ? r_time - r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && arr_ok && arr_fit) begin
            r_mem[{r_ecls, r_tail[r_ecls]}] <= r_time;
        end
        if (i_cmd.rd_head) begin
            r_rdata <= r_mem[{r_best, r_head[r_best]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_s_tuser[0];
            r_ecls <= i_s_tuser[2:1];
            r_time <= i_s_tdata;
        end
        if (i_cmd.mul_nt) begin
            r_nt <= NT_W'(r_cnt[i_cmd.cls]) * NT_W'(r_time);
        end
        if (i_cmd.load_num) begin
            r_quo <= DIV_W'(num_val);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= quo_sh;
            r_rem <= rem2;
        end
        if (i_cmd.load_out) begin
            r_odata <= {2'b00, r_busy, r_wait, r_best, r_started, r_drp, r_adm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlim <= CNT_W'(FIFO_DEPTH);
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_wt[c]   <= WT_W'(256);
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
                r_admt[c] <= '0;
                r_qsum[c] <= '0;
                r_dsum[c] <= '0;
            end
            r_busy    <= 1'b0;
            r_scls    <= '0;
            r_sarr    <= '0;
            r_adm     <= 1'b0;
            r_drp     <= 1'b0;
            r_started <= 1'b0;
            r_wait    <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_bestp   <= '0;
            r_oval    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QLIM: r_qlim  <= i_cfg_data[CNT_W-1:0];
                    CFG_WT0:  r_wt[0] <= i_cfg_data;
                    CFG_WT1:  r_wt[1] <= i_cfg_data;
                    CFG_WT2:  r_wt[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                r_adm     <= arr_ok && arr_fit;
                r_drp     <= arr_ok && !arr_fit;
                r_started <= 1'b0;
                r_wait    <= '0;
                r_found   <= 1'b0;
                r_best    <= '0;
                r_bestp   <= '0;
                if (arr_ok && arr_fit) begin
                    r_tail[r_ecls] <= r_tail[r_ecls] + PTR_W'(1);
                    r_cnt[r_ecls]  <= r_cnt[r_ecls] + CNT_W'(1);
                    r_admt[r_ecls] <= admt_add[ADM_W] ? '1 : admt_add[ADM_W-1:0];
                    r_qsum[r_ecls] <= qsum_add[QSUM_W] ? '1 : qsum_add[QSUM_W-1:0];
                end
                if (r_type && r_busy) begin
                    r_dsum[r_scls] <= dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];
                    r_busy <= 1'b0;
                end
            end
            if (i_cmd.eval && (r_cnt[i_cmd.cls] != '0) && (!r_found || pri > r_bestp)) begin
                r_found <= 1'b1;
                r_best  <= i_cmd.cls;
                r_bestp <= pri;
            end
            if (i_cmd.pop) begin
                r_head[r_best] <= r_head[r_best] + PTR_W'(1);
                r_cnt[r_best]  <= r_cnt[r_best] - CNT_W'(1);
                r_qsum[r_best] <= (r_qsum[r_best] >= QSUM_W'(r_rdata)) ?
                                  r_qsum[r_best] - QSUM_W'(r_rdata) : '0;
                r_scls    <= r_best;
                r_sarr    <= r_rdata;
                r_busy    <= 1'b1;
                r_started <= 1'b1;
                r_wait    <= pop_wait;
            end
            if (i_cmd.load_out) begin
                r_oval <= 1'b1;
            end else if (i_m_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.found    = r_found;
    assign o_sts.out_free = !r_oval || i_m_tready;
    assign o_m_tvalid     = r_oval;
    assign o_m_tdata      = r_odata;

endmodule

/* test/tb_pdws_checker.sv */
// Checker for the weighted delay scheduler: predicts each result from observed transactions.
`timescale 1ns / 1ps
module tb_pdws_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [pdws_pkg::TIME_W-1:0]     i_s_tdata,
    input  logic [pdws_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [pdws_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [pdws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import pdws_pkg::*;

    typedef struct packed {
        logic              busy;
        logic [TIME_W-1:0] wait_t;
        logic [CLS_W-1:0]  cls;
        logic              started;
        logic              dropped;
        logic              admitted;
    } t_sched_result;

    localparam longint unsigned QSUM_SAT = (64'd1 << QSUM_W) - 1;
    localparam longint unsigned DSUM_SAT = (64'd1 << DSUM_W) - 1;
    localparam longint unsigned CNT32_SAT = 64'hFFFF_FFFF;

    longint unsigned arrivals [NUM_CLASSES][FIFO_DEPTH];
    int              head [NUM_CLASSES];
    int              tail [NUM_CLASSES];
    int              depth [NUM_CLASSES];
    longint unsigned admits [NUM_CLASSES];
    longint unsigned qsum [NUM_CLASSES];
    longint unsigned dsum [NUM_CLASSES];
    longint unsigned weight [NUM_CLASSES];
    int              qlimit;
    logic            busy;
    int              cur_cls;
    longint unsigned cur_arrival;
    t_sched_result   result_q[$];

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                longint unsigned top);
        longint unsigned s;
        s = a + b;
        return (s < a || s > top) ? top : s;
    endfunction

    function automatic longint unsigned class_priority(int c, longint unsigned t);
        longint unsigned num;
        longint unsigned avg;
        logic [79:0]     prod;
        num = longint'(depth[c]) * t + dsum[c];
        num = (qsum[c] >= num) ? 0 : num - qsum[c];
        if (admits[c] == 0) return 0;
        avg = num / admits[c];
        prod = 80'(avg) * 80'(weight[c]);
        return (prod[79:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    endfunction

    task automatic predict_event(logic kind, logic [CLS_W-1:0] cls_in, logic [TIME_W-1:0] t_in);
        t_sched_result   r;
        longint unsigned t;
        longint unsigned a;
        longint unsigned p;
        longint unsigned best_p;
        int              lim;
        int              c;
        int              best;
        logic            found;
        r = '0;
        t = t_in;
        lim = (qlimit > FIFO_DEPTH) ? FIFO_DEPTH : qlimit;
        c = cls_in;
        if (!kind) begin
            if (c < NUM_CLASSES) begin
                if (depth[c] < lim) begin
                    arrivals[c][tail[c]] = t;
                    tail[c] = (tail[c] + 1) % FIFO_DEPTH;
                    depth[c]++;
                    admits[c] = sat_sum(admits[c], 1, CNT32_SAT);
                    qsum[c] = sat_sum(qsum[c], t, QSUM_SAT);
                    r.admitted = 1'b1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else if (busy) begin
            dsum[cur_cls] = sat_sum(dsum[cur_cls], (t >= cur_arrival) ? t - cur_arrival : 0,
                                    DSUM_SAT);
            busy = 1'b0;
        end
        if (!busy) begin
            found = 1'b0;
            best = 0;
            best_p = 0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (depth[k] > 0) begin
                    p = class_priority(k, t);
                    if (!found || p > best_p) begin
                        found = 1'b1;
                        best = k;
                        best_p = p;
                    end
                end
            end
            if (found) begin
                a = arrivals[best][head[best]];
                head[best] = (head[best] + 1) % FIFO_DEPTH;
                depth[best]--;
                qsum[best] = (qsum[best] >= a) ? qsum[best] - a : 0;
                cur_cls = best;
                cur_arrival = a;
                busy = 1'b1;
                r.started = 1'b1;
                r.cls = CLS_W'(best);
                r.wait_t = (t >= a) ? TIME_W'(t - a) : '0;
            end
        end
        r.busy = busy;
        result_q.push_back(r);
    endtask

    assign o_pending = result_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                head[k] = 0;
                tail[k] = 0;
                depth[k] = 0;
                admits[k] = 0;
                qsum[k] = 0;
                dsum[k] = 0;
                weight[k] = 256;
            end
            qlimit = 64;
            busy = 1'b0;
            cur_cls = 0;
            cur_arrival = 0;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QLIM: qlimit = i_cfg_data[6:0];
                    CFG_WT0:  weight[0] = i_cfg_data;
                    CFG_WT1:  weight[1] = i_cfg_data;
                    CFG_WT2:  weight[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_sched_result'(i_m_tdata[$bits(t_sched_result)-1:0]);
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got != want || i_m_tdata[OUT_DATA_W-1:$bits(t_sched_result)] != 0) begin
                        $display("%0t: result mismatch expected adm=%b drp=%b st=%b cls=%0d wait=%0d busy=%b",
                                 $time, want.admitted, want.dropped, want.started, want.cls,
                                 want.wait_t, want.busy);
                        $display("%0t:                 actual adm=%b drp=%b st=%b cls=%0d wait=%0d busy=%b",
                                 $time, got.admitted, got.dropped, got.started, got.cls,
                                 got.wait_t, got.busy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_event(i_s_tuser[0], i_s_tuser[2:1], i_s_tdata);
        end
    end
endmodule

/* test/tb_top.sv */
// Testbench top for the weighted delay scheduler: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
    import pdws_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [TIME_W-1:0]     i_s_tdata;
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    logic                  quiet;
    logic [TIME_W-1:0]     clock_now;

    pad_weighted_delay_scheduler_core uut (.*);

    tb_pdws_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= quiet || ($urandom_range(99) >= 11);
    end

    task automatic send_event(logic kind, logic [CLS_W-1:0] cls, logic [TIME_W-1:0] t);
        if (!quiet && $urandom_range(99) < 11) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= {cls, kind};
        i_s_tdata <= t;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_events(int count);
        logic [CLS_W-1:0] cls;
        int               pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 3)
                clock_now = clock_now - $urandom_range(1, 5000);
            else if (pick < 6)
                clock_now = clock_now + $urandom;
            else
                clock_now = clock_now + $urandom_range(0, 800);
            cls = ($urandom_range(99) < 3) ? 2'd3 : CLS_W'($urandom_range(2));
            send_event($urandom_range(99) < 45, cls, clock_now);
        end
    endtask

    task automatic load_config(int qlim, int w0, int w1, int w2);
        write_reg(CFG_QLIM, CFG_DATA_W'(qlim));
        write_reg(CFG_WT0, CFG_DATA_W'(w0));
        write_reg(CFG_WT1, CFG_DATA_W'(w1));
        write_reg(CFG_WT2, CFG_DATA_W'(w2));
    endtask

    initial begin
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_QLIM;
        i_cfg_data = '0;
        clock_now = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle completion, out-of-range class, time extremes and a backwards step
        send_event(1'b1, 2'd0, 32'd0);
        send_event(1'b0, 2'd3, 32'd5);
        send_event(1'b0, 2'd0, 32'd10);
        send_event(1'b0, 2'd1, 32'd20);
        send_event(1'b0, 2'd2, 32'd30);
        send_event(1'b0, 2'd2, 32'd40);
        send_event(1'b1, 2'd0, 32'd100);
        send_event(1'b1, 2'd3, 32'd90);
        send_event(1'b1, 2'd0, 32'hFFFF_FFFF);
        send_event(1'b0, 2'd1, 32'hFFFF_FFFF);
        send_event(1'b0, 2'd0, 32'hFFFF_FFF0);
        send_event(1'b1, 2'd0, 32'hFFFF_FFFF);
        send_event(1'b1, 2'd0, 32'hFFFF_FFFF);
        send_event(1'b1, 2'd0, 32'hFFFF_FFFF);
        drain();

        load_config(0, 65535, 0, 1);
        send_event(1'b0, 2'd0, 32'd1000);
        send_event(1'b0, 2'd1, 32'd1001);
        send_event(1'b0, 2'd2, 32'd1002);
        send_event(1'b1, 2'd0, 32'd1003);
        random_events(60);
        drain();

        load_config(1, 65535, 65535, 65535);
        random_events(230);
        drain();

        load_config(127, 0, 0, 0);
        clock_now = 32'hFFFF_0000;
        random_events(230);
        drain();

        load_config(64, 65535, 256, 1);
        quiet = 1'b1;
        random_events(200);
        quiet = 1'b0;
        drain();

        load_config($urandom_range(1, 8), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535));
        random_events(230);
        drain();

        load_config(3, 256, 512, 128);
        random_events(200);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* sim.f */
sv/pdws_pkg.sv
sv/pdws_ctrl.sv
sv/pdws_dp.sv
sv/pad_weighted_delay_scheduler_core.sv
test/tb_pdws_checker.sv
test/tb_top.sv
